FILE: sv/bfya_pkg.sv
`default_nettype none

package bfya_pkg;

	// Field widths of one transaction.
	localparam int YEAR_W = 12;
	localparam int TAG_W  = 16;

	// Default number of entries held by the FIFO.
	localparam int DEF_CAPACITY = 5;

	// Depth of the command queue between the front and the back.
	// It must be a power of two so the pointers wrap on their own.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// The mean divider retires this many quotient bits per cycle.
	localparam int DIV_RADIX_BITS = 3;
	localparam int DIV_STEPS      = YEAR_W / DIV_RADIX_BITS;
	localparam int DIV_CNT_W      = $clog2(DIV_STEPS + 1);

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} bfya_cmd_t;

	typedef struct packed {
		bfya_cmd_t          cmd;
		logic [YEAR_W-1:0]  year;
		logic [TAG_W-1:0]   entry_tag;
	} bfya_in_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  mean_year;
		logic               removed_valid;
		logic [TAG_W-1:0]   removed_tag;
	} bfya_out_t;

	// A command after classification by the front.
	typedef struct packed {
		logic               insert;
		logic               year_known;
		logic [YEAR_W-1:0]  year;
		logic [TAG_W-1:0]   tag;
	} bfya_job_t;

endpackage

`default_nettype wire

FILE: sv/bfya_front.sv
`default_nettype none

module bfya_front
	import bfya_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire bfya_in_t  in_item,
	output logic           job_valid,
	input  wire logic      job_ready,
	output bfya_job_t      job
);

	bfya_job_t           queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	bfya_job_t           classified;
	logic                push;
	logic                pop;

	// Classify the incoming command once so the back does not repeat it.
	always_comb begin
		classified.insert     = (in_item.cmd == CMD_INSERT);
		classified.year_known = (in_item.year != '0);
		classified.year       = in_item.year;
		classified.tag        = in_item.entry_tag;
	end

	assign in_ready  = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign job_valid = (count_q != '0);
	assign job       = queue_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = job_valid && job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= classified;
		end
	end

endmodule

`default_nettype wire

FILE: sv/bfya_div.sv
`default_nettype none

module bfya_div
	import bfya_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        start,
	input  wire logic [YEAR_W+$clog2(CAPACITY+1)-1:0]        dividend,
	input  wire logic [$clog2(CAPACITY+1)-1:0]               divisor,
	output logic                                             done,
	output logic [YEAR_W-1:0]                                quotient
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = YEAR_W + CNT_W;

	// The quotient always fits in YEAR_W bits, so the partial remainder
	// starts as the upper bits of the dividend and stays below the divisor.
	logic [CNT_W-1:0]      rem_q;
	logic [YEAR_W-1:0]     quo_q;
	logic [CNT_W-1:0]      dvs_q;
	logic [DIV_CNT_W-1:0]  step_q;
	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      rem_n;
	logic [YEAR_W-1:0]     quo_n;

	always_comb begin
		logic [CNT_W:0] trial;
		logic [CNT_W:0] diff;
		logic           ge;
		rem_n = rem_q;
		quo_n = quo_q;
		for (int i = 0; i < DIV_RADIX_BITS; i++) begin
			trial = {rem_n, quo_n[YEAR_W-1]};
			diff  = trial - {1'b0, dvs_q};
			ge    = (trial >= {1'b0, dvs_q});
			rem_n = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_n = {quo_n[YEAR_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= DIV_CNT_W'(DIV_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[SUM_W-1:YEAR_W];
			quo_q <= dividend[YEAR_W-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: sv/bfya_back.sv
`default_nettype none

module bfya_back
	import bfya_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       job_valid,
	output logic            job_ready,
	input  wire bfya_job_t  job,
	output logic            out_valid,
	input  wire logic       out_ready,
	output bfya_out_t       out_item
);

	localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int SUM_W  = YEAR_W + CNT_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} bfya_state_t;

	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic [TAG_W-1:0]  tag;
	} bfya_entry_t;

	bfya_state_t        state_q;
	bfya_job_t          job_q;
	logic [SLOT_W-1:0]  head_q;
	logic [CNT_W-1:0]   fill_q;
	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   known_q;
	bfya_entry_t        mem [CAPACITY];
	bfya_entry_t        rd_q;
	bfya_out_t          res_q;
	bfya_out_t          out_q;
	logic               out_valid_q;

	logic               full;
	logic               drop;
	logic               old_known;
	logic [CNT_W:0]     tail_sum;
	logic [CNT_W:0]     tail_wrap;
	logic [SLOT_W-1:0]  tail;
	logic [SLOT_W-1:0]  head_next;
	logic [SUM_W-1:0]   sum_drop;
	logic [CNT_W-1:0]   known_drop;
	logic [SUM_W-1:0]   sum_new;
	logic [CNT_W-1:0]   known_new;
	logic               wr_en;
	logic               div_start;
	logic               div_done;
	logic [YEAR_W-1:0]  div_quot;
	logic               out_load;

	assign job_ready = (state_q == S_IDLE);

	// The slot after the newest entry; head plus fill stays below twice the
	// capacity, so one conditional subtract wraps it.
	always_comb begin
		tail_sum  = (CNT_W+1)'(head_q) + (CNT_W+1)'(fill_q);
		tail_wrap = (tail_sum >= (CNT_W+1)'(CAPACITY)) ?
			tail_sum - (CNT_W+1)'(CAPACITY) : tail_sum;
		tail      = tail_wrap[SLOT_W-1:0];
		head_next = (head_q == SLOT_W'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
	end

	// Running sum and count after the command: the oldest entry leaves when
	// it is popped or evicted, then an inserted entry joins.
	always_comb begin
		full       = (fill_q == CNT_W'(CAPACITY));
		drop       = job_q.insert ? full : (fill_q != '0);
		old_known  = (rd_q.year != '0);
		sum_drop   = drop ? sum_q - SUM_W'(rd_q.year) : sum_q;
		known_drop = (drop && old_known) ? known_q - 1'b1 : known_q;
		sum_new    = job_q.insert ? sum_drop + SUM_W'(job_q.year) : sum_drop;
		known_new  = (job_q.insert && job_q.year_known) ? known_drop + 1'b1 : known_drop;
	end

	assign wr_en     = (state_q == S_EXEC) && job_q.insert;
	assign div_start = wr_en && (known_new != '0);
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);

	bfya_div #(
		.CAPACITY (CAPACITY)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_new),
		.divisor  (known_new),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			known_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					sum_q   <= sum_new;
					known_q <= known_new;
					if (drop) begin
						head_q <= head_next;
					end
					if (job_q.insert && !full) begin
						fill_q <= fill_q + 1'b1;
					end else if (!job_q.insert && drop) begin
						fill_q <= fill_q - 1'b1;
					end
					state_q <= div_start ? S_DIV : S_OUT;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			job_q <= job;
		end
		if (state_q == S_EXEC) begin
			res_q.mean_year     <= '0;
			res_q.removed_valid <= !job_q.insert && drop;
			res_q.removed_tag   <= (!job_q.insert && drop) ? rd_q.tag : '0;
		end else if ((state_q == S_DIV) && div_done) begin
			res_q.mean_year <= div_quot;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	// Store with one write port at the tail and a registered read at the head.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail] <= '{year: job_q.year, tag: job_q.tag};
		end
		rd_q <= mem[head_q];
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_W+1)'(fill_q) <= (CNT_W+1)'(CAPACITY))
		else $error("fill count exceeds capacity");

	a_known_le_fill: assert property (@(posedge clk) disable iff (!arst_n)
		known_q <= fill_q)
		else $error("known-year count exceeds fill count");

	a_sum_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(known_q == '0) |-> (sum_q == '0))
		else $error("year sum nonzero with no known years");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_W+1)'(head_q) < (CNT_W+1)'(CAPACITY))
		else $error("head slot out of range");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

endmodule

`default_nettype wire

FILE: sv/bounded_fifo_with_year_average.sv
// Bounded FIFO of year/tag entries that reports the mean of the known years.
// Input channel in_valid/in_ready/in_item carries one command transaction:
// cmd selects insert or remove, year (0 means unknown) and entry_tag are
// the inserted record. Output channel out_valid/out_ready/out_item carries
// exactly one result transaction per command, in command order.
// An insert into a full FIFO evicts the oldest entry first. Each insert
// reports the truncated mean of the nonzero years then held, or 0 if none.
// A remove reports the tag of the popped entry with removed_valid set, or
// removed_valid and removed_tag both 0 when the FIFO is empty.
// Commands are handled one at a time by the back end. An insert whose result
// needs a division passes there through pop, update, the radix-8 mean
// divider and output load, in that order; other commands skip the divider.
// A two-entry command queue keeps in_ready high while the back end works
// until it fills, and a result register holds the finished transaction
// while out_ready is low; the back end stops only on a full result register.
// Reset empties the FIFO, the command queue and the result register.

`default_nettype none

module bounded_fifo_with_year_average
	import bfya_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire bfya_in_t   in_item,
	output logic            out_valid,
	input  wire logic       out_ready,
	output bfya_out_t       out_item
);

	// Classified commands flow from the front to the back through this
	// handshake; the front queue absorbs bursts while the back is busy.
	logic       job_valid;
	logic       job_ready;
	bfya_job_t  job;

	bfya_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	// The back owns the entry store, the running sum and count of known
	// years, and the divider that forms the mean after an insert if any is known.
	bfya_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire
